### rtl/acp_pkg.sv
// ----------------------------------------------------------------------------
// acp_pkg
// Types and constants for the two-color-per-byte attribute pixel store.
// ----------------------------------------------------------------------------
package acp_pkg;

  localparam int unsigned STORE_BYTES_DEF = 8192;
  localparam int unsigned LINE_WIDTH_W    = 10;
  localparam int unsigned POS_W           = 10;
  localparam int unsigned COLOR_W         = 4;
  localparam int unsigned BITS_W          = 8;
  localparam int unsigned SUM_W           = 21;
  localparam int unsigned FULL_ADDR_W     = SUM_W - 3;

  localparam logic [LINE_WIDTH_W-1:0] LINE_WIDTH_RESET = LINE_WIDTH_W'(320);

  typedef enum logic {
    ACT_READ  = 1'b0,
    ACT_WRITE = 1'b1
  } acp_action_e;

  typedef struct packed {
    acp_action_e        action;
    logic [POS_W-1:0]   pos_x;
    logic [POS_W-1:0]   pos_y;
    logic [COLOR_W-1:0] pen;
  } acp_in_t;

  typedef struct packed {
    logic [COLOR_W-1:0] pixel_color;
    logic               out_of_range;
  } acp_out_t;

  // one store entry: color pair and the eight pixel bits
  typedef struct packed {
    logic [COLOR_W-1:0] color_hi;
    logic [COLOR_W-1:0] color_lo;
    logic [BITS_W-1:0]  bits;
  } acp_entry_t;

  typedef struct packed {
    logic       we;
    acp_entry_t entry;
    acp_out_t   res;
  } acp_upd_t;

endpackage

### rtl/acp_addr.sv
// ----------------------------------------------------------------------------
// acp_addr
// Byte address and range check for one pixel position.
// ----------------------------------------------------------------------------
module acp_addr import acp_pkg::*; #(
  parameter int unsigned StoreBytes = STORE_BYTES_DEF,
  parameter int unsigned AddrW      = $clog2(StoreBytes)
) (
  input  logic [LINE_WIDTH_W-1:0] line_width_i,
  input  logic [POS_W-1:0]        pos_x_i,
  input  logic [POS_W-1:0]        pos_y_i,
  output logic [AddrW-1:0]        addr_o,
  output logic                    oor_o
);

  localparam logic [FULL_ADDR_W-1:0] Depth = FULL_ADDR_W'(StoreBytes);

  logic [POS_W+LINE_WIDTH_W-1:0] prod;
  logic [SUM_W-1:0]              sum;
  logic [FULL_ADDR_W-1:0]        full_addr;

  assign prod      = pos_y_i * line_width_i;
  assign sum       = SUM_W'(prod) + SUM_W'(pos_x_i);
  assign full_addr = sum[SUM_W-1:3];
  assign oor_o     = (full_addr >= Depth);
  assign addr_o    = full_addr[AddrW-1:0];

endmodule

### rtl/acp_mem.sv
// ----------------------------------------------------------------------------
// acp_mem
// Entry memory with registered read and a clearing sweep after reset.
// ----------------------------------------------------------------------------
module acp_mem import acp_pkg::*; #(
  parameter int unsigned StoreBytes = STORE_BYTES_DEF,
  parameter int unsigned AddrW      = $clog2(StoreBytes)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output acp_entry_t       rd_data_o,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  acp_entry_t       wr_data_i,
  output logic             busy_o
);

  localparam logic [AddrW-1:0] LastAddr = AddrW'(StoreBytes - 1);

  acp_entry_t       mem [StoreBytes];
  acp_entry_t       rd_data_q;
  logic [AddrW-1:0] clr_q, clr_d;
  logic             busy_q, busy_d;

  always_comb begin
    clr_d  = clr_q;
    busy_d = busy_q;
    if (busy_q) begin
      clr_d = clr_q + AddrW'(1);
      if (clr_q == LastAddr) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q  <= '0;
      busy_q <= 1'b1;
    end else begin
      clr_q  <= clr_d;
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      mem[clr_q] <= '0;
    end else if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;
  assign busy_o    = busy_q;

endmodule

### rtl/acp_update.sv
// ----------------------------------------------------------------------------
// acp_update
// Pixel read and write-back logic for one fetched entry.
// ----------------------------------------------------------------------------
module acp_update import acp_pkg::*; (
  input  acp_entry_t         entry_i,
  input  acp_action_e        action_i,
  input  logic [2:0]         col_i,
  input  logic [COLOR_W-1:0] pen_i,
  input  logic               oor_i,
  output acp_upd_t           upd_o
);

  logic [2:0]         bit_idx;
  logic [3:0]         ones;
  logic [COLOR_W-1:0] lo_n;
  logic [COLOR_W-1:0] hi_n;
  logic [BITS_W-1:0]  bits_n;
  logic [COLOR_W-1:0] rd_color;

  assign bit_idx = 3'(7) - col_i;

  always_comb begin
    ones = '0;
    for (int i = 0; i < BITS_W; i++) begin
      ones = ones + 4'(entry_i.bits[i]);
    end
  end

  always_comb begin
    lo_n   = entry_i.color_lo;
    hi_n   = entry_i.color_hi;
    bits_n = entry_i.bits;
    if (pen_i != entry_i.color_lo && pen_i != entry_i.color_hi) begin
      // at least half of the bits set: replace the clear-bit color
      if (ones > 4'd3) begin
        lo_n = pen_i;
      end else begin
        hi_n = pen_i;
      end
    end
    if (pen_i == lo_n) begin
      bits_n[bit_idx] = 1'b0;
    end else if (pen_i == hi_n) begin
      bits_n[bit_idx] = 1'b1;
    end
  end

  assign rd_color = entry_i.bits[bit_idx] ? entry_i.color_hi : entry_i.color_lo;

  always_comb begin
    upd_o.we                 = (action_i == ACT_WRITE) && !oor_i;
    upd_o.entry.color_hi     = hi_n;
    upd_o.entry.color_lo     = lo_n;
    upd_o.entry.bits         = bits_n;
    upd_o.res.out_of_range   = oor_i;
    upd_o.res.pixel_color    = '0;
    if (action_i == ACT_READ && !oor_i) begin
      upd_o.res.pixel_color = rd_color;
    end
  end

endmodule

### rtl/attribute_clash_pixel_store.sv
// ----------------------------------------------------------------------------
// attribute_clash_pixel_store
// Bitmap store with a color pair per 8-pixel byte; pixel read and write.
//
//   channel   dir   handshake               payload
//   in        in    in_valid_i/in_ready_o    in_item_i   (acp_in_t)
//   out       out   out_valid_o/out_ready_i  out_item_o  (acp_out_t)
//   cfg       in    cfg_we_i                 cfg_data_i  (line_width)
//
// One item per cycle while in_ready_o is high; results come from an output register.
// The entry memory is read in stage 1 and written back in stage 2;
// a one-entry forward register covers a write to the entry just fetched.
// After reset a clearing sweep over all StoreBytes entries runs with in_ready_o low.
// A stalled output holds the whole pipeline and the memory read data.
// ----------------------------------------------------------------------------
module attribute_clash_pixel_store import acp_pkg::*; #(
  parameter int unsigned StoreBytes = STORE_BYTES_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [LINE_WIDTH_W-1:0] cfg_data_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  acp_in_t                 in_item_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output acp_out_t                out_item_o
);

  localparam int unsigned AddrW = $clog2(StoreBytes);

  logic [LINE_WIDTH_W-1:0] line_width_q;
  logic                    adv;
  logic                    accept;
  logic                    mem_busy;
  logic [AddrW-1:0]        in_addr;
  logic                    in_oor;

  // stage 1: address known, memory read issued
  logic               s1_valid_q;
  acp_action_e        s1_action_q;
  logic [2:0]         s1_col_q;
  logic [COLOR_W-1:0] s1_pen_q;
  logic [AddrW-1:0]   s1_addr_q;
  logic               s1_oor_q;

  // stage 2: entry fetched, update and write back
  logic               s2_valid_q;
  acp_action_e        s2_action_q;
  logic [2:0]         s2_col_q;
  logic [COLOR_W-1:0] s2_pen_q;
  logic [AddrW-1:0]   s2_addr_q;
  logic               s2_oor_q;

  logic               fwd_valid_q;
  logic [AddrW-1:0]   fwd_addr_q;
  acp_entry_t         fwd_data_q;

  logic               out_valid_q, out_valid_d;
  acp_out_t           out_item_q;

  acp_entry_t         rd_data;
  acp_entry_t         cur_entry;
  acp_upd_t           upd;
  logic               wr_en;

  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = adv && !mem_busy;
  assign accept     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_width_q <= LINE_WIDTH_RESET;
    end else if (cfg_we_i) begin
      line_width_q <= cfg_data_i;
    end
  end

  acp_addr #(
    .StoreBytes (StoreBytes),
    .AddrW      (AddrW)
  ) u_addr (
    .line_width_i (line_width_q),
    .pos_x_i      (in_item_i.pos_x),
    .pos_y_i      (in_item_i.pos_y),
    .addr_o       (in_addr),
    .oor_o        (in_oor)
  );

  acp_mem #(
    .StoreBytes (StoreBytes),
    .AddrW      (AddrW)
  ) u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (adv && s1_valid_q),
    .rd_addr_i (s1_addr_q),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (s2_addr_q),
    .wr_data_i (upd.entry),
    .busy_o    (mem_busy)
  );

  // write that landed at the edge the current entry was read
  assign cur_entry = (fwd_valid_q && fwd_addr_q == s2_addr_q) ? fwd_data_q : rd_data;

  acp_update u_update (
    .entry_i  (cur_entry),
    .action_i (s2_action_q),
    .col_i    (s2_col_q),
    .pen_i    (s2_pen_q),
    .oor_i    (s2_oor_q),
    .upd_o    (upd)
  );

  assign wr_en = adv && s2_valid_q && upd.we;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      fwd_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q  <= accept;
      s2_valid_q  <= s1_valid_q;
      fwd_valid_q <= wr_en;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_action_q <= in_item_i.action;
      s1_col_q    <= in_item_i.pos_x[2:0];
      s1_pen_q    <= in_item_i.pen;
      s1_addr_q   <= in_addr;
      s1_oor_q    <= in_oor;
      s2_action_q <= s1_action_q;
      s2_col_q    <= s1_col_q;
      s2_pen_q    <= s1_pen_q;
      s2_addr_q   <= s1_addr_q;
      s2_oor_q    <= s1_oor_q;
      fwd_addr_q  <= s2_addr_q;
      fwd_data_q  <= upd.entry;
      out_item_q  <= upd.res;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (adv) begin
      out_valid_d = s2_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // no item enters or writes back while the clearing sweep runs
  assert property (@(posedge clk_i) disable iff (!rst_ni) mem_busy |-> !in_ready_o)
    else $error("item taken during clearing sweep");

  assert property (@(posedge clk_i) disable iff (!rst_ni) mem_busy |-> !wr_en)
    else $error("write-back during clearing sweep");

  // out-of-range items never reach the memory
  assert property (@(posedge clk_i) disable iff (!rst_ni) (s2_valid_q && s2_oor_q) |-> !wr_en)
    else $error("write-back of out-of-range item");

  // out-of-range result carries no color
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (out_valid_o && out_item_o.out_of_range) |-> (out_item_o.pixel_color == '0))
    else $error("color on out-of-range result");

endmodule
